[hw/rtl/stb_pkg.sv]
// Shared types and constants for the software timer bank.
package stb_pkg;

  localparam int OP_W    = 3;
  localparam int DUR_W   = 16;
  localparam int SEL_W   = 3;
  localparam int STAT_W  = 2;
  localparam int SLOT_W  = 3;
  localparam int VAL_W   = 16;
  localparam int TIME_W  = 16;
  localparam int INC_W   = 8;
  localparam int IN_W    = 24;  // 22 payload bits, padded to whole bytes
  localparam int OUT_W   = 40;  // 37 payload bits, padded to whole bytes

  // slot entry in RAM: {one_shot, target, elapsed}
  localparam int ENTRY_W = 1 + DUR_W + VAL_W;

  localparam int MAX_REPORTS = 8;
  localparam int CNT_W       = 4;

  localparam logic [INC_W-1:0] TICK_INC_RESET = 8'd2;

  localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
  localparam logic [OP_W-1:0] OP_ONCE     = 3'd1;
  localparam logic [OP_W-1:0] OP_PERIODIC = 3'd2;
  localparam logic [OP_W-1:0] OP_CANCEL   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ     = 3'd4;
  localparam logic [OP_W-1:0] OP_WAIT     = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SLOT  = 2'd1;
  localparam logic [STAT_W-1:0] ST_ZERO_DUR = 2'd2;

  typedef struct packed {
    logic accept;         // capture input word
    logic tick_start;     // advance time, reset sweep pointer and report count
    logic scan_start;     // pointer to highest slot for allocation
    logic ptr_inc;
    logic ptr_dec;
    logic rd_ptr;         // RAM read at sweep pointer
    logic rd_sel;         // RAM read at selected slot
    logic alloc;          // claim slot at pointer
    logic no_slot;
    logic refuse;
    logic finish_simple;  // cancel, wait start, unused codes
    logic read_done;
    logic tick_upd;       // write back one slot after a tick
    logic push_mid;       // held result out, not last
    logic push_last;      // held result out, last
  } stb_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic dur_zero;
    logic sel_ok;
    logic ptr_active;
    logic ptr_last;
    logic ptr_one;
    logic hit;
    logic cnt_zero;
    logic cnt_full;
    logic out_free;
  } stb_sts_t;

endpackage

[hw/rtl/stb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module stb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/stb_ctrl.sv]
// Sequencing state machine for the software timer bank.
module stb_ctrl
  import stb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  stb_sts_t sts,
  output stb_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_RWAIT  = 3'd3;
  localparam logic [2:0] S_TCHECK = 3'd4;
  localparam logic [2:0] S_TUPD   = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0] state, state_next;
  logic       mid_push;

  assign in_ready = (state == S_IDLE);
  // a new expiry displaces an already held one
  assign mid_push = sts.hit && !sts.cnt_zero && !sts.cnt_full;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.op)
          OP_TICK: begin
            cmd.tick_start = 1'b1;
            state_next     = S_TCHECK;
          end
          OP_ONCE, OP_PERIODIC: begin
            if (sts.dur_zero) begin
              cmd.refuse = 1'b1;
              state_next = S_EMIT;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
          OP_READ: begin
            cmd.rd_sel = sts.sel_ok;
            state_next = S_RWAIT;
          end
          default: begin
            cmd.finish_simple = 1'b1;
            state_next        = S_EMIT;
          end
        endcase
      end
      S_SCAN: begin
        if (!sts.ptr_active) begin
          cmd.alloc  = 1'b1;
          state_next = S_EMIT;
        end else if (sts.ptr_one) begin
          cmd.no_slot = 1'b1;
          state_next  = S_EMIT;
        end else begin
          cmd.ptr_dec = 1'b1;
        end
      end
      S_RWAIT: begin
        cmd.read_done = 1'b1;
        state_next    = S_EMIT;
      end
      S_TCHECK: begin
        if (sts.ptr_active) begin
          cmd.rd_ptr = 1'b1;
          state_next = S_TUPD;
        end else if (sts.ptr_last) begin
          state_next = S_EMIT;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_TUPD: begin
        if (!mid_push || sts.out_free) begin
          cmd.tick_upd = 1'b1;
          cmd.push_mid = mid_push;
          if (sts.ptr_last) begin
            state_next = S_EMIT;
          end else begin
            cmd.ptr_inc = 1'b1;
            state_next  = S_TCHECK;
          end
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.push_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hw/rtl/stb_dp.sv]
// Datapath: slot RAM, active bits, time counter, result and output registers.
module stb_dp
  import stb_pkg::*;
#(
  parameter int TIMER_COUNT = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  stb_cmd_t          cmd,
  output stb_sts_t          sts,
  input  logic [IN_W-1:0]   in_data,
  input  logic              cfg_wr_en,
  input  logic [INC_W-1:0]  cfg_wr_data,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [OUT_W-1:0]  out_data,
  output logic              out_expired,
  output logic              out_last
);

  localparam int NSLOTS = TIMER_COUNT + 1;
  localparam int SW     = $clog2(NSLOTS);
  localparam int IW     = (SW > SLOT_W) ? SW : SLOT_W;

  logic [OP_W-1:0]   op_r;
  logic [DUR_W-1:0]  dur_r;
  logic [SEL_W-1:0]  sel_r;
  logic [SW-1:0]     ptr;
  logic [CNT_W-1:0]  cnt;
  logic [NSLOTS-1:0] active;
  logic [TIME_W-1:0] gt;
  logic [INC_W-1:0]  tick_inc;

  logic [STAT_W-1:0] res_status;
  logic [SLOT_W-1:0] res_slot;
  logic              res_expired;
  logic [VAL_W-1:0]  res_value;

  logic [STAT_W-1:0] o_status;
  logic [SLOT_W-1:0] o_slot;
  logic [VAL_W-1:0]  o_value;
  logic [TIME_W-1:0] o_time;

  logic               wr_en, rd_en;
  logic [SW-1:0]      wr_addr, rd_addr;
  logic [ENTRY_W-1:0] wr_data, rd_data;

  logic [IW-1:0]     sel_ext, ptr_ext;
  logic [SW-1:0]     sel_idx;
  logic              sel_ok;
  logic [VAL_W-1:0]  rd_elapsed, el_new;
  logic [DUR_W-1:0]  rd_target;
  logic              rd_one_shot;
  logic              hit;
  logic              out_free;
  logic              push;

  assign sel_ext = IW'(sel_r);
  assign ptr_ext = IW'(ptr);
  assign sel_idx = sel_ext[SW-1:0];
  assign sel_ok  = (32'(sel_r) <= TIMER_COUNT);

  assign rd_elapsed  = rd_data[VAL_W-1:0];
  assign rd_target   = rd_data[VAL_W +: DUR_W];
  assign rd_one_shot = rd_data[ENTRY_W-1];
  assign el_new      = rd_elapsed + VAL_W'(tick_inc);
  assign hit         = (el_new >= rd_target);

  assign out_free = !out_valid || out_ready;
  assign push     = cmd.push_mid || cmd.push_last;

  assign sts.op         = op_r;
  assign sts.dur_zero   = (dur_r == '0);
  assign sts.sel_ok     = sel_ok;
  assign sts.ptr_active = active[ptr];
  assign sts.ptr_last   = (ptr == SW'(TIMER_COUNT));
  assign sts.ptr_one    = (ptr == SW'(1));
  assign sts.hit        = hit;
  assign sts.cnt_zero   = (cnt == '0);
  assign sts.cnt_full   = (cnt == CNT_W'(MAX_REPORTS));
  assign sts.out_free   = out_free;

  // RAM port steering; an expired one-shot keeps its advanced count for later reads
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr;
    wr_data = {rd_one_shot, rd_target, (hit && !rd_one_shot) ? VAL_W'(0) : el_new};
    if (cmd.alloc) begin
      wr_en   = 1'b1;
      wr_data = {op_r == OP_ONCE, dur_r, VAL_W'(0)};
    end else if (cmd.tick_upd) begin
      wr_en = 1'b1;
    end else if (cmd.finish_simple && op_r == OP_WAIT) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = {1'b1, dur_r, VAL_W'(0)};
    end
  end

  assign rd_en   = cmd.rd_ptr || cmd.rd_sel;
  assign rd_addr = cmd.rd_sel ? sel_idx : ptr;

  stb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NSLOTS)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // input capture and sweep pointer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_data[OP_W-1:0];
      dur_r <= in_data[OP_W +: DUR_W];
      sel_r <= in_data[OP_W+DUR_W +: SEL_W];
    end
    if (cmd.tick_start) begin
      ptr <= '0;
    end else if (cmd.scan_start) begin
      ptr <= SW'(TIMER_COUNT);
    end else if (cmd.ptr_inc) begin
      ptr <= ptr + 1'b1;
    end else if (cmd.ptr_dec) begin
      ptr <= ptr - 1'b1;
    end
  end

  // control state: active bits, time, tick increment, report count
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= '0;
      gt       <= '0;
      tick_inc <= TICK_INC_RESET;
      cnt      <= '0;
    end else begin
      if (cfg_wr_en) begin
        tick_inc <= cfg_wr_data;
      end
      if (cmd.tick_start) begin
        gt  <= gt + TIME_W'(tick_inc);
        cnt <= '0;
      end
      if (cmd.alloc) begin
        active[ptr] <= 1'b1;
      end
      if (cmd.tick_upd && hit) begin
        if (rd_one_shot) begin
          active[ptr] <= 1'b0;
        end
        if (!sts.cnt_full) begin
          cnt <= cnt + 1'b1;
        end
      end
      if (cmd.finish_simple) begin
        if (op_r == OP_CANCEL && sel_ok) begin
          active[sel_idx] <= 1'b0;
        end
        if (op_r == OP_WAIT) begin
          active[0] <= (dur_r != '0);
        end
      end
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      res_status  <= ST_OK;
      res_slot    <= '0;
      res_expired <= 1'b0;
      res_value   <= '0;
    end else if (cmd.refuse || cmd.no_slot) begin
      res_status  <= cmd.refuse ? ST_ZERO_DUR : ST_NO_SLOT;
      res_slot    <= '0;
      res_expired <= 1'b0;
      res_value   <= '0;
    end else if (cmd.alloc) begin
      res_status  <= ST_OK;
      res_slot    <= ptr_ext[SLOT_W-1:0];
      res_expired <= 1'b0;
      res_value   <= '0;
    end else if (cmd.read_done) begin
      res_status  <= ST_OK;
      res_slot    <= sel_r;
      res_expired <= 1'b0;
      res_value   <= sel_ok ? rd_elapsed : VAL_W'(0);
    end else if (cmd.finish_simple) begin
      res_status  <= ST_OK;
      res_slot    <= (op_r == OP_CANCEL) ? sel_r : SLOT_W'(0);
      res_expired <= 1'b0;
      res_value   <= '0;
    end else if (cmd.tick_upd && hit && !sts.cnt_full) begin
      res_status  <= ST_OK;
      res_slot    <= ptr_ext[SLOT_W-1:0];
      res_expired <= 1'b1;
      res_value   <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      o_status    <= res_status;
      o_slot      <= res_slot;
      out_expired <= res_expired;
      o_value     <= res_value;
      o_time      <= gt;
      out_last    <= cmd.push_last;
    end
  end

  assign out_data = {3'b000, o_time, o_value, o_slot, o_status};

endmodule

[hw/rtl/software_timer_bank.sv]
// Software timer bank: TIMER_COUNT+1 timer slots, time counter, expiry reporting.
// Steps: a tick sweeps the slot RAM up from slot 0, reading and writing back each active slot
//   and holding while a displaced expiry waits for the output register; a start scans down to
//   the highest free slot; cancel, wait and unused codes end at decode; read data is registered.
// Throughput: one word at a time; the next word is taken once the last result is in the
//   output register, which may still wait on m_axis_tready.
// Reset (rst, synchronous): all slots inactive, time 0, tick increment 2, output empty.
module software_timer_bank
  import stb_pkg::*;
#(
  parameter int TIMER_COUNT = 7
) (
  input  logic             clk,
  input  logic             rst,
  // input words
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // operation[2:0], duration[18:3], slot_select[21:19]
  // result words
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // status[1:0], slot_index[4:2],
                                           // elapsed_value[20:5], time_now[36:21]
  output logic             m_axis_tuser,   // expired
  output logic             m_axis_tlast,   // final result of the input word
  // tick increment register
  input  logic             cfg_wr_en,
  input  logic [INC_W-1:0] cfg_wr_data
);

  stb_cmd_t cmd;
  stb_sts_t sts;

  // controller: walks decode, slot scan, tick sweep and result hand-off
  stb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: slot RAM with {one_shot, target, elapsed}, active flags in flops,
  // one held result so the last expiry of a tick can be flagged once the sweep ends
  stb_dp #(
    .TIMER_COUNT (TIMER_COUNT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_data     (s_axis_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_data    (m_axis_tdata),
    .out_expired (m_axis_tuser),
    .out_last    (m_axis_tlast)
  );

endmodule

[sim/timer_bank_checker.sv]
// Checker for the software timer bank: predicts every result word and compares it.
`timescale 1ns / 100ps

module timer_bank_checker
  import stb_pkg::*;
#(
  parameter int TIMER_COUNT = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [IN_W-1:0]      s_axis_tdata,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [OUT_W-1:0]     m_axis_tdata,
  input  logic                 m_axis_tuser,
  input  logic                 m_axis_tlast,
  input  logic                 cfg_wr_en,
  input  logic [INC_W-1:0]     cfg_wr_data,
  output int                   mismatch_count,
  output int                   results_pending,
  output logic [TIMER_COUNT:0] slots_written    // slots whose elapsed count has been set
);

  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic              expired;
    logic [VAL_W-1:0]  value;
    logic [TIME_W-1:0] now;
    logic              last;
  } timer_result_t;

  // shadow of the block's state
  logic [VAL_W-1:0]  slot_elapsed [TIMER_COUNT+1];
  logic [DUR_W-1:0]  slot_target  [TIMER_COUNT+1];
  logic              slot_once    [TIMER_COUNT+1];
  logic [TIME_W-1:0] clock_ms;
  logic [INC_W-1:0]  tick_inc;

  timer_result_t expected_words[$];
  timer_result_t got_word;
  timer_result_t want_word;

  function automatic timer_result_t make_result(logic [STAT_W-1:0] status,
                                                logic [SLOT_W-1:0] slot, logic expired,
                                                logic [VAL_W-1:0] value, logic last);
    timer_result_t r;
    r.status  = status;
    r.slot    = slot;
    r.expired = expired;
    r.value   = value;
    r.now     = clock_ms;
    r.last    = last;
    return r;
  endfunction

  // allocation: highest free slot among 1..TIMER_COUNT
  task automatic start_delay(input logic [DUR_W-1:0] dur, input logic once);
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    status = ST_NO_SLOT;
    slot   = '0;
    if (dur == '0) begin
      status = ST_ZERO_DUR;
    end else begin
      for (int s = TIMER_COUNT; s > 0; s--) begin
        if (status == ST_NO_SLOT && slot_target[s] == '0) begin
          slot_elapsed[s]  = '0;
          slot_target[s]   = dur;
          slot_once[s]     = once;
          slots_written[s] = 1'b1;
          slot             = s[SLOT_W-1:0];
          status           = ST_OK;
        end
      end
    end
    expected_words.push_back(make_result(status, slot, 1'b0, '0, 1'b1));
  endtask

  task automatic predict_word(input logic [IN_W-1:0] w);
    logic [OP_W-1:0]  op;
    logic [DUR_W-1:0] dur;
    logic [SEL_W-1:0] sel;
    timer_result_t    hits [MAX_REPORTS];
    int               n;
    op  = w[OP_W-1:0];
    dur = w[OP_W +: DUR_W];
    sel = w[OP_W+DUR_W +: SEL_W];
    n   = 0;
    case (op)
      OP_TICK: begin
        clock_ms = clock_ms + TIME_W'(tick_inc);
        for (int s = 0; s <= TIMER_COUNT; s++) begin
          if (slot_target[s] != '0) begin
            slot_elapsed[s] = slot_elapsed[s] + VAL_W'(tick_inc);
            if (slot_elapsed[s] >= slot_target[s]) begin
              if (n < MAX_REPORTS) begin
                hits[n] = make_result(ST_OK, s[SLOT_W-1:0], 1'b1, '0, 1'b0);
                n++;
              end
              if (slot_once[s]) slot_target[s] = '0;
              else              slot_elapsed[s] = '0;
            end
          end
        end
        if (n == 0) begin
          expected_words.push_back(make_result(ST_OK, '0, 1'b0, '0, 1'b1));
        end else begin
          hits[n-1].last = 1'b1;
          for (int k = 0; k < n; k++) expected_words.push_back(hits[k]);
        end
      end
      OP_ONCE:     start_delay(dur, 1'b1);
      OP_PERIODIC: start_delay(dur, 1'b0);
      OP_CANCEL: begin
        if (32'(sel) <= TIMER_COUNT) slot_target[sel] = '0;
        expected_words.push_back(make_result(ST_OK, sel, 1'b0, '0, 1'b1));
      end
      OP_READ: begin
        expected_words.push_back(make_result(ST_OK, sel, 1'b0,
                                             (32'(sel) <= TIMER_COUNT) ?
                                             slot_elapsed[sel] : VAL_W'(0),
                                             1'b1));
      end
      OP_WAIT: begin
        slot_elapsed[0]  = '0;
        slot_target[0]   = dur;
        slot_once[0]     = 1'b1;
        slots_written[0] = 1'b1;
        expected_words.push_back(make_result(ST_OK, '0, 1'b0, '0, 1'b1));
      end
      default: expected_words.push_back(make_result(ST_OK, '0, 1'b0, '0, 1'b1));
    endcase
  endtask

  task automatic check_word();
    got_word.status  = m_axis_tdata[1:0];
    got_word.slot    = m_axis_tdata[4:2];
    got_word.value   = m_axis_tdata[20:5];
    got_word.now     = m_axis_tdata[36:21];
    got_word.expired = m_axis_tuser;
    got_word.last    = m_axis_tlast;
    if (expected_words.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t checker: result word with none pending: st=%0d slot=%0d exp=%0b",
                 $realtime, got_word.status, got_word.slot, got_word.expired,
                 " val=%0d now=%0d last=%0b", got_word.value, got_word.now, got_word.last);
    end else begin
      want_word = expected_words.pop_front();
      if (got_word.status  !== want_word.status  || got_word.slot !== want_word.slot ||
          got_word.expired !== want_word.expired || got_word.value !== want_word.value ||
          got_word.now     !== want_word.now     || got_word.last !== want_word.last) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("%0t checker: mismatch want st=%0d slot=%0d exp=%0b val=%0d now=%0d",
                   $realtime, want_word.status, want_word.slot, want_word.expired,
                   want_word.value, want_word.now, " last=%0b", want_word.last);
          $display("%0t checker:          got  st=%0d slot=%0d exp=%0b val=%0d now=%0d",
                   $realtime, got_word.status, got_word.slot, got_word.expired,
                   got_word.value, got_word.now, " last=%0b", got_word.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= TIMER_COUNT; s++) begin
        slot_elapsed[s] = '0;
        slot_target[s]  = '0;
        slot_once[s]    = 1'b0;
      end
      clock_ms      = '0;
      tick_inc      = TICK_INC_RESET;
      slots_written = '0;
      expected_words.delete();
    end else begin
      // results of earlier words leave before this edge's word is predicted
      if (m_axis_tvalid && m_axis_tready) check_word();
      if (cfg_wr_en) tick_inc = cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready) predict_word(s_axis_tdata);
    end
    results_pending = expected_words.size();
  end

endmodule

[sim/tb.sv]
// Testbench top for the software timer bank: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;
  import stb_pkg::*;

  localparam int TIMER_COUNT  = 7;
  localparam int RESET_CYCLES = 12;
  localparam int HOLD_CYCLES  = 300;              // long receiver hold-off
  localparam int STALL_LIMIT  = 1500;             // cycles with no handshake or register write
  localparam int SETTLE_CYCLES = TIMER_COUNT + 8; // block's own tail after the last word

  // operation codes the block ignores
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;  // operation[2:0], duration[18:3], slot_select[21:19]
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;       // status[1:0], slot_index[4:2],
                                        // elapsed_value[20:5], time_now[36:21]
  logic             m_axis_tuser;       // expired
  logic             m_axis_tlast;       // final result of the input word
  logic             cfg_wr_en = 1'b0;
  logic [INC_W-1:0] cfg_wr_data = '0;

  int                   mismatch_count;
  int                   results_pending;
  logic [TIMER_COUNT:0] slots_written;

  // stimulus knobs, percent of cycles spent idle on each side
  int send_idle_pct = 0;
  int rcv_idle_pct  = 0;
  int cur_inc       = TICK_INC_RESET;
  int words_sent    = 0;
  int hold_asked    = 0;
  int hold_taken    = 0;
  int hold_left     = 0;
  int stall_cycles  = 0;

  always #4 clk = ~clk;

  software_timer_bank #(
    .TIMER_COUNT(TIMER_COUNT)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  timer_bank_checker #(
    .TIMER_COUNT(TIMER_COUNT)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .m_axis_tlast   (m_axis_tlast),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .mismatch_count (mismatch_count),
    .results_pending(results_pending),
    .slots_written  (slots_written)
  );

  // Receiver: random back-pressure, or a long hold-off when the stimulus asks for one.
  // While held, the block finishes one word, parks its result and then stalls s_axis.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_taken != hold_asked) begin
      hold_taken = hold_asked;
      hold_left = HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Watchdog: any handshake or register write restarts the count.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_wr_en) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offer one word and hold it until taken; then maybe leave a random gap.
  // Called and returning at a rising edge, so tvalid gets one assignment per step.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [DUR_W-1:0] dur,
                           input logic [SEL_W-1:0] sel);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_W-OP_W-DUR_W-SEL_W){1'b0}}, sel, dur, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    words_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Sender pauses until every predicted word has come back, then lets the block settle.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (results_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only written while the block is idle
  task automatic write_tick_inc(input int value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value[INC_W-1:0];
    cur_inc = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly delays of a few ticks at the current increment, so slots come and go;
  // some zero, full-range and all-ones durations.
  function automatic logic [DUR_W-1:0] pick_duration();
    int r;
    int span;
    r    = $urandom_range(99);
    span = (cur_inc == 0) ? 8 : cur_inc * 6;
    if (r < 5)  return '0;
    if (r < 15) return DUR_W'($urandom);
    if (r < 20) return '1;
    return DUR_W'($urandom_range(span, 1));
  endfunction

  // One random word; reads only touch slots whose elapsed count has been set.
  task automatic send_random_word();
    int               r;
    logic [SEL_W-1:0] sel;
    r = $urandom_range(99);
    if (r < 40) begin
      send_word(OP_TICK, DUR_W'($urandom), SEL_W'($urandom));
    end else if (r < 55) begin
      send_word(OP_ONCE, pick_duration(), SEL_W'($urandom));
    end else if (r < 70) begin
      send_word(OP_PERIODIC, pick_duration(), SEL_W'($urandom));
    end else if (r < 80) begin
      send_word(OP_CANCEL, DUR_W'($urandom), SEL_W'($urandom));
    end else if (r < 90 && slots_written != '0) begin
      do sel = SEL_W'($urandom_range(TIMER_COUNT)); while (!slots_written[sel]);
      send_word(OP_READ, DUR_W'($urandom), sel);
    end else if (r < 96) begin
      send_word(OP_WAIT, pick_duration(), SEL_W'($urandom));
    end else begin
      send_word($urandom_range(1) ? OP_SPARE_LO : OP_SPARE_HI, DUR_W'($urandom),
                SEL_W'($urandom));
    end
  endtask

  // Every slot busy, delay at most one tick: a nonzero-increment tick reports eight expiries.
  task automatic fill_and_expire();
    int hi;
    hi = (cur_inc == 0) ? 1 : cur_inc;
    for (int s = 1; s <= TIMER_COUNT; s++)
      send_word(OP_CANCEL, DUR_W'($urandom), s[SEL_W-1:0]);
    for (int s = 1; s <= TIMER_COUNT; s++)
      send_word($urandom_range(1) ? OP_ONCE : OP_PERIODIC, DUR_W'($urandom_range(hi, 1)),
                SEL_W'($urandom));
    send_word(OP_WAIT, DUR_W'($urandom_range(hi, 1)), SEL_W'($urandom));
    send_word(OP_TICK, DUR_W'($urandom), SEL_W'($urandom));
  endtask

  task automatic run_random(input int count);
    int goal;
    int r;
    goal = words_sent + count;
    while (words_sent < goal) begin
      r = $urandom_range(99);
      if (r < 4)
        repeat ($urandom_range(20, 8)) send_word(OP_TICK, DUR_W'($urandom), SEL_W'($urandom));
      else if (r < 6) fill_and_expire();
      else            send_random_word();
    end
  endtask

  initial begin
    send_idle_pct = 8;
    rcv_idle_pct  = 70;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_tick_inc(1);

    // directed: increment 1, each slot started once, then a few ticks
    send_word(OP_TICK, '0, '0);          // nothing active: one plain result
    send_word(OP_WAIT, '0, '0);          // zero wait: slot 0 stays inactive
    send_word(OP_READ, '0, 3'd0);
    send_word(OP_ONCE, '0, '0);          // zero duration refused
    send_word(OP_PERIODIC, '0, '1);      // zero duration refused
    send_word(OP_ONCE, 16'd1, '0);       // slot 7
    send_word(OP_PERIODIC, 16'd3, '0);   // slot 6
    send_word(OP_ONCE, 16'hFFFF, '0);    // slot 5
    send_word(OP_PERIODIC, 16'd2, '0);   // slot 4
    send_word(OP_ONCE, 16'd5, '0);       // slot 3
    send_word(OP_ONCE, 16'd7, '0);       // slot 2
    send_word(OP_PERIODIC, 16'd1, '0);   // slot 1
    send_word(OP_ONCE, 16'd9, '0);       // bank full
    send_word(OP_WAIT, 16'd4, '0);
    send_word(OP_TICK, '1, '1);          // slots 1 and 7 expire
    send_word(OP_TICK, '0, '0);          // slots 1 and 4
    send_word(OP_READ, '0, 3'd6);
    send_word(OP_CANCEL, '0, 3'd5);
    send_word(OP_CANCEL, '1, 3'd5);      // already inactive
    send_word(OP_SPARE_LO, 16'hFFFF, '1); // unused codes
    send_word(OP_SPARE_HI, '0, '0);
    send_word(OP_TICK, '0, '0);
    send_word(OP_TICK, '0, '0);          // wait slot expires and is reported
    send_word(OP_READ, '0, 3'd7);
    send_word(OP_CANCEL, '0, 3'd7);
    wait_for_results();

    // sender mostly busy, receiver mostly stalled; largest increment
    write_tick_inc(255);
    run_random(65);
    wait_for_results();
    run_random(65);
    wait_for_results();

    // roles swapped; a zero increment first, then a random one
    send_idle_pct = 70;
    rcv_idle_pct  = 8;
    write_tick_inc(0);
    run_random(40);
    wait_for_results();
    write_tick_inc($urandom_range(254, 1));
    run_random(100);
    wait_for_results();

    // no idling; the receiver holds off once while words keep coming
    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    write_tick_inc(255);
    run_random(40);
    hold_asked = hold_asked + 1;
    run_random(90);

    wait_for_results();
    if (mismatch_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/stb_pkg.sv
hw/rtl/stb_ram.sv
hw/rtl/stb_ctrl.sv
hw/rtl/stb_dp.sv
hw/rtl/software_timer_bank.sv
sim/timer_bank_checker.sv
sim/tb.sv
